### design/bqd_pkg.sv
// Shared constants, types and the microcode program of the biquad filter core.
package bqd_pkg;

    // Default widths of the sample, coefficient fraction and delay state.
    localparam int DEF_SAMPLE_BITS    = 24;
    localparam int DEF_COEF_FRAC_BITS = 28;
    localparam int DEF_STATE_BITS     = 40;

    // Coefficient registers are always 32 bits wide.
    localparam int COEF_BITS    = 32;
    localparam int ADDR_BITS    = 5;
    localparam int REG_IDX_BITS = 3;

    typedef logic [REG_IDX_BITS-1:0] t_reg_idx;

    // Register indexes, which are also the coefficient select codes.
    localparam t_reg_idx REG_B0 = 3'd0;
    localparam t_reg_idx REG_B1 = 3'd1;
    localparam t_reg_idx REG_B2 = 3'd2;
    localparam t_reg_idx REG_A1 = 3'd3;
    localparam t_reg_idx REG_A2 = 3'd4;

    // Accumulator operation codes.
    localparam int ACC_OP_BITS = 3;
    typedef logic [ACC_OP_BITS-1:0] t_acc_op;

    localparam t_acc_op ACC_HOLD    = 3'd0;
    localparam t_acc_op ACC_P_Z1    = 3'd1;
    localparam t_acc_op ACC_P_Z2    = 3'd2;
    localparam t_acc_op ACC_SUB_P   = 3'd3;
    localparam t_acc_op ACC_T_SUB_P = 3'd4;

    // Step counter of the sequencer.
    localparam int STEP_BITS = 3;
    typedef logic [STEP_BITS-1:0] t_step;

    localparam t_step LAST_STEP = 3'd6;

    // One control word of the microcode program.
    typedef struct packed {
        t_reg_idx coef_sel;  // coefficient fed to the multiplier
        logic     opnd_y;    // multiplier operand: 1 selects y, 0 selects x
        t_acc_op  acc_op;    // accumulator update from the registered product
        logic     wr_y;      // capture saturated accumulator as y
        logic     wr_t;      // park the rounded product in the temp register
        logic     wr_z1;     // write saturated accumulator to delay one
        logic     wr_z2;     // write saturated accumulator to delay two
        logic     done;      // wait here until the output register is free
    } t_uop;

    // The program. The multiplier result of step n is consumed in step n+1.
    function automatic t_uop ucode(input t_step step);
        t_uop u;
        u = '{coef_sel: REG_B0, opnd_y: 1'b0, acc_op: ACC_HOLD, wr_y: 1'b0,
              wr_t: 1'b0, wr_z1: 1'b0, wr_z2: 1'b0, done: 1'b0};
        case (step)
            3'd0: begin
                u.coef_sel = REG_B0;
            end
            3'd1: begin
                u.coef_sel = REG_B1;
                u.acc_op   = ACC_P_Z1;
            end
            3'd2: begin
                u.coef_sel = REG_B2;
                u.acc_op   = ACC_P_Z2;
                u.wr_y     = 1'b1;
            end
            3'd3: begin
                u.coef_sel = REG_A1;
                u.opnd_y   = 1'b1;
                u.wr_t     = 1'b1;
            end
            3'd4: begin
                u.coef_sel = REG_A2;
                u.opnd_y   = 1'b1;
                u.acc_op   = ACC_SUB_P;
            end
            3'd5: begin
                u.acc_op = ACC_T_SUB_P;
                u.wr_z1  = 1'b1;
            end
            3'd6: begin
                u.wr_z2 = 1'b1;
                u.done  = 1'b1;
            end
            default: begin
                u.done = 1'b1;
            end
        endcase
        return u;
    endfunction

endpackage

### design/biquad_iir_filter_core.sv
// Top level of the biquad filter core: APB registers, microcode sequencer and datapath.
//
// Second-order IIR section in transposed direct form II.
// Input channel: i_in_valid, o_in_stall, i_sample_in (signed Q1.23) and
// i_restart, which clears both delay states before that sample.
// Output channel: o_out_valid, i_out_stall, o_sample_out and o_overflow.
// A transaction on either channel completes at a rising edge with valid high
// and stall low.
// The coefficients b0, b1, b2, a1, a2 (signed Q4.28) sit at byte addresses
// 0, 4, 8, 12 and 16 of the APB port; write them while the core is idle.
// Each sample runs a seven-step microcode program through one shared
// multiplier, and the input stalls until that program has finished.
// The output register frees the input side: the next sample is accepted
// while a finished result still waits for the receiver.
// When the receiver stalls with a result pending, the next sample finishes
// its program and holds in its last step until the output register frees.
// Reset clears the coefficients and delay states and empties both channels.
module biquad_iir_filter_core
    import bqd_pkg::*;
#(
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    parameter int STATE_BITS     = DEF_STATE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_BITS-1:0]          paddr,
    input  logic [COEF_BITS-1:0]          pwdata,
    output logic [COEF_BITS-1:0]          prdata,
    output logic                          pready,

    // Input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_restart,

    // Output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_overflow
);

    // Product, rounded product and accumulator widths.
    localparam int PW    = COEF_BITS + SAMPLE_BITS;
    localparam int RW    = PW + 1 - COEF_FRAC_BITS;
    localparam int ACC_W = ((RW > STATE_BITS) ? RW : STATE_BITS) + 2;
    localparam int HALF  = 1 << (COEF_FRAC_BITS - 1);

    // Coefficient registers.
    logic signed [COEF_BITS-1:0]   r_coef_b0, r_coef_b1, r_coef_b2, r_coef_a1, r_coef_a2;

    // Sequencer state.
    logic                          r_busy;
    t_step                         r_step;
    t_uop                          uop;

    // Datapath registers.
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic signed [PW-1:0]          r_prod;
    logic signed [RW-1:0]          r_t;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [STATE_BITS-1:0]  r_z1, r_z2;
    logic                          r_ovf;

    // Output register.
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_ovf;

    logic                          cfg_wr;
    logic                          in_acc;
    logic                          out_acc;
    logic                          out_load;
    logic signed [COEF_BITS-1:0]   mul_coef;
    logic signed [SAMPLE_BITS-1:0] mul_opnd;
    logic signed [PW:0]            p_half;
    logic signed [PW:0]            p_shift;
    logic signed [RW-1:0]          p_rnd;
    logic signed [ACC_W-1:0]       p_ext;
    logic signed [ACC_W-1:0]       t_ext;
    logic signed [ACC_W-1:0]       z1_ext, z2_ext;
    logic signed [ACC_W-1:0]       n_acc;
    logic                          y_ovf, z_ovf;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic signed [STATE_BITS-1:0]  z_sat;

    // APB write strobe and read mux.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (t_reg_idx'(paddr[ADDR_BITS-1:2]))
            REG_B0:  prdata = r_coef_b0;
            REG_B1:  prdata = r_coef_b1;
            REG_B2:  prdata = r_coef_b2;
            REG_A1:  prdata = r_coef_a1;
            REG_A2:  prdata = r_coef_a2;
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b0 <= '0;
            r_coef_b1 <= '0;
            r_coef_b2 <= '0;
            r_coef_a1 <= '0;
            r_coef_a2 <= '0;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[ADDR_BITS-1:2]))
                REG_B0:  r_coef_b0 <= pwdata;
                REG_B1:  r_coef_b1 <= pwdata;
                REG_B2:  r_coef_b2 <= pwdata;
                REG_A1:  r_coef_a1 <= pwdata;
                REG_A2:  r_coef_a2 <= pwdata;
                default: ;
            endcase
        end
    end

    // Handshakes. The output register is written when it is empty or drains now.
    assign in_acc      = i_in_valid && !r_busy;
    assign o_in_stall  = r_busy;
    assign out_acc     = r_out_valid && !i_out_stall;
    assign uop         = ucode(r_step);
    assign out_load    = r_busy && uop.done && (!r_out_valid || !i_out_stall);

    // Sequencer: step counter that holds in the last step until the output register takes the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (in_acc) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            if (uop.done) begin
                if (out_load) begin
                    r_busy <= 1'b0;
                    r_step <= '0;
                end
            end else begin
                r_step <= r_step + t_step'(1);
            end
        end
    end

    // Multiplier operand selection.
    always_comb begin
        case (uop.coef_sel)
            REG_B0:  mul_coef = r_coef_b0;
            REG_B1:  mul_coef = r_coef_b1;
            REG_B2:  mul_coef = r_coef_b2;
            REG_A1:  mul_coef = r_coef_a1;
            REG_A2:  mul_coef = r_coef_a2;
            default: mul_coef = '0;
        endcase
        mul_opnd = uop.opnd_y ? r_y : r_x;
    end

    // Round the registered product to the state scaling, halves toward plus infinity.
    assign p_half  = {r_prod[PW-1], r_prod} + (PW+1)'(HALF);
    assign p_shift = p_half >>> COEF_FRAC_BITS;
    assign p_rnd   = p_shift[RW-1:0];
    assign p_ext   = {{(ACC_W-RW){p_rnd[RW-1]}}, p_rnd};
    assign t_ext   = {{(ACC_W-RW){r_t[RW-1]}}, r_t};
    assign z1_ext  = {{(ACC_W-STATE_BITS){r_z1[STATE_BITS-1]}}, r_z1};
    assign z2_ext  = {{(ACC_W-STATE_BITS){r_z2[STATE_BITS-1]}}, r_z2};

    // Accumulator update selected by the control word.
    always_comb begin
        case (uop.acc_op)
            ACC_P_Z1:    n_acc = p_ext + z1_ext;
            ACC_P_Z2:    n_acc = p_ext + z2_ext;
            ACC_SUB_P:   n_acc = r_acc - p_ext;
            ACC_T_SUB_P: n_acc = t_ext - p_ext;
            default:     n_acc = r_acc;
        endcase
    end

    // Saturation of the accumulator to the sample and to the state range.
    always_comb begin
        y_ovf = !((&r_acc[ACC_W-1:SAMPLE_BITS-1]) || !(|r_acc[ACC_W-1:SAMPLE_BITS-1]));
        z_ovf = !((&r_acc[ACC_W-1:STATE_BITS-1]) || !(|r_acc[ACC_W-1:STATE_BITS-1]));
        if (y_ovf) begin
            y_sat = r_acc[ACC_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                   : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else begin
            y_sat = r_acc[SAMPLE_BITS-1:0];
        end
        if (z_ovf) begin
            z_sat = r_acc[ACC_W-1] ? {1'b1, {(STATE_BITS-1){1'b0}}}
                                   : {1'b0, {(STATE_BITS-1){1'b1}}};
        end else begin
            z_sat = r_acc[STATE_BITS-1:0];
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= i_sample_in;
        end
        if (r_busy) begin
            r_prod <= mul_coef * mul_opnd;
            r_acc  <= n_acc;
            if (uop.wr_y) begin
                r_y <= y_sat;
            end
            if (uop.wr_t) begin
                r_t <= p_rnd;
            end
        end
    end

    // Delay states and the sticky overflow of the sample in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z1  <= '0;
            r_z2  <= '0;
            r_ovf <= 1'b0;
        end else if (in_acc) begin
            if (i_restart) begin
                r_z1 <= '0;
                r_z2 <= '0;
            end
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            if (uop.wr_y && y_ovf) begin
                r_ovf <= 1'b1;
            end
            if (uop.wr_z1) begin
                r_z1 <= z_sat;
                if (z_ovf) begin
                    r_ovf <= 1'b1;
                end
            end
            if (uop.wr_z2) begin
                r_z2 <= z_sat;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sample <= r_y;
            r_out_ovf    <= r_ovf || z_ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_overflow   = r_out_ovf;

    // An idle sequencer always waits at the first step.
    a_idle_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_step == '0)
        else $error("sequencer idle away from the first step");

    // The step counter never runs past the end of the program.
    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= LAST_STEP)
        else $error("step counter beyond the last step");

    // An accepted sample starts the program at its first step.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_busy && r_step == '0)
        else $error("accepted sample did not start the program");

    // A result appears only after the last step of a running program.
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy && r_step == LAST_STEP))
        else $error("result loaded outside the last step");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the biquad filter core with its own fixed-point predictor.
module tb_top;
    import bqd_pkg::*;

    localparam int SMP_W      = DEF_SAMPLE_BITS;
    localparam int FRAC_W     = DEF_COEF_FRAC_BITS;
    localparam int STATE_W    = DEF_STATE_BITS;
    localparam int NUM_COEFS  = 5;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 16;
    localparam int ITEMS_PER_BLOCK = 54;
    localparam int BLOCKS_PER_MODE = 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 40;

    // Register slots past the last coefficient; writes there must be ignored.
    localparam t_reg_idx REG_SPARE_FIRST = 3'd5;
    localparam t_reg_idx REG_SPARE_LAST  = 3'd7;

    // Random coefficient flavors.
    localparam int COEF_FULL     = 0;
    localparam int COEF_MODERATE = 1;
    localparam int COEF_EXTREME  = 2;

    localparam logic signed [SMP_W-1:0] SAMPLE_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [SMP_W-1:0] SAMPLE_MIN = {1'b1, {(SMP_W-1){1'b0}}};
    localparam logic [COEF_BITS-1:0] COEF_ONE  = 1 << FRAC_W;
    localparam logic [COEF_BITS-1:0] COEF_HALF = 1 << (FRAC_W - 1);
    localparam logic [COEF_BITS-1:0] COEF_MAX  = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic [COEF_BITS-1:0] COEF_MIN  = {1'b1, {(COEF_BITS-1){1'b0}}};

    typedef struct {
        logic signed [SMP_W-1:0] sample;
        logic                    restart;
    } sample_item_t;

    typedef struct {
        logic signed [SMP_W-1:0] sample;
        logic                    overflow;
    } filter_result_t;

    // Clock, reset and block inputs, all known from time zero.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [COEF_BITS-1:0] pwdata  = '0;
    logic [COEF_BITS-1:0] prdata;
    logic                 pready;

    logic                    i_in_valid  = 1'b0;
    logic                    o_in_stall;
    logic signed [SMP_W-1:0] i_sample_in = '0;
    logic                    i_restart   = 1'b0;

    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [SMP_W-1:0] o_sample_out;
    logic                    o_overflow;

    // Predictor state: coefficients and the two delay registers.
    logic signed [COEF_BITS-1:0] coef_q [NUM_COEFS];
    logic signed [STATE_W-1:0]   delay_one_q = '0;
    logic signed [STATE_W-1:0]   delay_two_q = '0;

    sample_item_t   pending_q [$];
    filter_result_t expected_q [$];

    logic in_fire       = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   err_count     = 0;
    int   cycle_count   = 0;

    biquad_iir_filter_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .i_restart    (i_restart),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_overflow   (o_overflow)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Coefficient times operand, rounded half up to the state scaling.
    function automatic longint scale_product(input logic signed [COEF_BITS-1:0] coef,
                                             input longint operand);
        longint prod;
        prod = longint'(coef) * operand + (longint'(1) <<< (FRAC_W - 1));
        return prod >>> FRAC_W;
    endfunction

    // Clamp to a signed range of the given width and note any clipping.
    function automatic longint clamp_to(input longint value, input int bits, inout bit hit);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (value > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (value < lo) begin
            hit = 1'b1;
            return lo;
        end
        return value;
    endfunction

    // One transposed direct form II step; the feedback uses the clamped output.
    function automatic filter_result_t filter_sample(input logic signed [SMP_W-1:0] x,
                                                     input logic restart);
        filter_result_t res;
        bit             sat;
        longint         y;
        longint         next_one;
        longint         next_two;
        sat = 1'b0;
        if (restart) begin
            delay_one_q = '0;
            delay_two_q = '0;
        end
        y = clamp_to(scale_product(coef_q[REG_B0], longint'(x)) + longint'(delay_one_q),
                     SMP_W, sat);
        next_one = scale_product(coef_q[REG_B1], longint'(x))
                 - scale_product(coef_q[REG_A1], y) + longint'(delay_two_q);
        next_two = scale_product(coef_q[REG_B2], longint'(x))
                 - scale_product(coef_q[REG_A2], y);
        delay_one_q = STATE_W'(clamp_to(next_one, STATE_W, sat));
        delay_two_q = STATE_W'(clamp_to(next_two, STATE_W, sat));
        res.sample   = SMP_W'(y);
        res.overflow = sat;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    function automatic void queue_sample(input logic signed [SMP_W-1:0] sample,
                                         input logic restart);
        sample_item_t item;
        item.sample  = sample;
        item.restart = restart;
        pending_q.push_back(item);
    endfunction

    // Mostly full-range samples, with extremes and small values mixed in.
    function automatic logic signed [SMP_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return SMP_W'($urandom);
        end
        if (pick < 75) begin
            case ($urandom_range(0, 3))
                0: return SAMPLE_MAX;
                1: return SAMPLE_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        return SMP_W'($urandom_range(0, 4095)) - SMP_W'(2048);
    endfunction

    function automatic logic [COEF_BITS-1:0] random_coef(input int flavor);
        case (flavor)
            COEF_FULL:     return $urandom;
            COEF_MODERATE: return $urandom_range(0, 2 * COEF_ONE - 1) - COEF_ONE;
            default:       return ($urandom_range(0, 1) != 0) ? COEF_MAX : COEF_MIN;
        endcase
    endfunction

    // APB write, followed by a read back of any real coefficient register.
    task automatic write_coef(input t_reg_idx idx, input logic [COEF_BITS-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= REG_A2) begin
            coef_q[idx] = value;
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            if (prdata !== value) begin
                report_mismatch($sformatf("register %0d reads %h, expected %h",
                                          idx, prdata, value));
            end
            @(negedge i_clk);
            penable <= 1'b0;
        end
        psel <= 1'b0;
    endtask

    task automatic write_coef_set(input logic [COEF_BITS-1:0] b0, input logic [COEF_BITS-1:0] b1,
                                  input logic [COEF_BITS-1:0] b2, input logic [COEF_BITS-1:0] a1,
                                  input logic [COEF_BITS-1:0] a2);
        write_coef(REG_B0, b0);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
        write_coef(REG_A1, a1);
        write_coef(REG_A2, a2);
    endtask

    // Wait until every queued sample went in and every result came out.
    task automatic wait_drained();
        while (pending_q.size() != 0 || i_in_valid || expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Input driver: presents the next sample once the current transaction completed.
    always @(negedge i_clk) begin : drive_samples
        sample_item_t item;
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                item = pending_q.pop_front();
                i_in_valid  <= 1'b1;
                i_sample_in <= item.sample;
                i_restart   <= item.restart;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Monitor: check finished results, then predict for accepted samples.
    always @(posedge i_clk) begin : check_results
        filter_result_t want;
        in_fire <= i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d overflow %0b with no sample pending",
                                              o_sample_out, o_overflow));
                end else begin
                    want = expected_q.pop_front();
                    if (o_sample_out !== want.sample) begin
                        report_mismatch($sformatf("sample_out %0d, expected %0d",
                                                  o_sample_out, want.sample));
                    end
                    if (o_overflow !== want.overflow) begin
                        report_mismatch($sformatf("overflow %0b, expected %0b",
                                                  o_overflow, want.overflow));
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                expected_q.push_back(filter_sample(i_sample_in, i_restart));
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("biquad_iir_filter_core verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int mode;
        int blk;
        int k;
        int flavor;
        foreach (coef_q[i]) begin
            coef_q[i] = '0;
        end
        send_idle_pct = 15;
        recv_idle_pct = 51;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // All coefficients zero after reset: the output must stay zero.
        queue_sample(SAMPLE_MAX, 1'b1);
        queue_sample(SAMPLE_MIN, 1'b0);
        queue_sample('1, 1'b0);
        wait_drained();

        // A plain unstable section with half-step products on odd samples.
        write_coef_set(COEF_ONE, COEF_HALF, -COEF_ONE, -(COEF_ONE << 1),
                       COEF_HALF + (COEF_HALF >> 1));
        queue_sample(SMP_W'(1), 1'b0);
        queue_sample('1, 1'b0);
        queue_sample(SAMPLE_MAX, 1'b0);
        queue_sample(SAMPLE_MIN, 1'b0);
        queue_sample('0, 1'b1);
        queue_sample(SMP_W'(24'h555555), 1'b0);
        queue_sample(SMP_W'(24'hAAAAAA), 1'b1);
        queue_sample(SAMPLE_MAX, 1'b0);
        wait_drained();

        // Extreme coefficients drive the output into saturation.
        write_coef_set(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN);
        queue_sample(SAMPLE_MAX, 1'b0);
        queue_sample(SAMPLE_MAX, 1'b0);
        queue_sample(SAMPLE_MIN, 1'b0);
        queue_sample(SAMPLE_MIN, 1'b0);
        queue_sample(SMP_W'(1), 1'b0);
        queue_sample(SAMPLE_MIN, 1'b1);
        queue_sample('0, 1'b0);
        wait_drained();

        // Rounding of exact halves, plus writes to unused slots that must be ignored.
        write_coef_set(COEF_HALF, '0, '0, '0, SMP_W'(1));
        write_coef(REG_SPARE_FIRST, COEF_MAX);
        write_coef(REG_SPARE_LAST, COEF_MIN);
        queue_sample(SMP_W'(1), 1'b1);
        queue_sample('1, 1'b0);
        queue_sample(SMP_W'(3), 1'b0);
        queue_sample(-SMP_W'(3), 1'b0);
        wait_drained();

        // Random part: three flow-control modes, several coefficient sets each.
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 51;
                end
                1: begin
                    send_idle_pct = 51;
                    recv_idle_pct = 15;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (blk = 0; blk < BLOCKS_PER_MODE; blk++) begin
                flavor = (blk + mode) % 3;
                write_coef_set(random_coef(flavor), random_coef(flavor), random_coef(flavor),
                               random_coef(flavor), random_coef(flavor));
                for (k = 0; k < ITEMS_PER_BLOCK; k++) begin
                    queue_sample(random_sample(), $urandom_range(0, 99) < 4);
                end
                wait_drained();
            end
        end

        if (err_count == 0) begin
            $display("biquad_iir_filter_core verification clean");
        end else begin
            $display("biquad_iir_filter_core verification failed");
        end
        $finish;
    end

endmodule
